### hdl/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg: shared types and constants of the shifting array list
// Command codes, cell control struct and fixed field widths.
// ----------------------------------------------------------------------------
package sal_pkg;

	localparam int unsigned OP_W      = 3;
	localparam int unsigned POS_W     = 7;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned COUNT_W   = 7;
	localparam int unsigned IN_DATA_W = 40;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned DEF_CAPACITY = 64;

	// command codes carried in the input tuser
	typedef enum logic [OP_W-1:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_INSERT = 3'd2,
		OP_ERASE  = 3'd3,
		OP_PUSH   = 3'd4,
		OP_POP    = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_RESIZE = 3'd7
	} op_t;

	// what every cell of the row does for an accepted command
	typedef enum logic [2:0] {
		CK_NONE,
		CK_READ,
		CK_WRITE,
		CK_INSERT,
		CK_ERASE,
		CK_PUSH,
		CK_FILL
	} cell_kind_t;

	// broadcast control from the sequencer to the cells
	typedef struct packed {
		logic       take;
		cell_kind_t kind;
	} cell_ctl_t;

endpackage

### hdl/sal_cell.sv
// ----------------------------------------------------------------------------
// sal_cell: one entry of the shifting array list
// Holds one element, loads the command value, or takes the entry of its
// left or right neighbor; captures its entry for a read at its own index.
// ----------------------------------------------------------------------------
module sal_cell #(
	parameter int unsigned IDX_W = 7,
	parameter int unsigned INDEX = 0
) (
	input  logic                      clk,
	input  sal_pkg::cell_ctl_t        ctl,
	input  logic [IDX_W-1:0]          pos,
	input  logic [IDX_W-1:0]          cnt,
	input  logic [sal_pkg::VAL_W-1:0] value,
	input  logic [sal_pkg::VAL_W-1:0] left,
	input  logic [sal_pkg::VAL_W-1:0] right,
	output logic [sal_pkg::VAL_W-1:0] data,
	output logic [sal_pkg::VAL_W-1:0] rd_s1
);
	import sal_pkg::*;

	typedef enum logic [1:0] {
		SEL_HOLD,
		SEL_LOAD,
		SEL_LEFT,
		SEL_RIGHT
	} sel_t;

	localparam logic [IDX_W:0] IDX_C  = (IDX_W+1)'(INDEX);
	localparam logic [IDX_W:0] NEXT_C = (IDX_W+1)'(INDEX + 1);

	logic [VAL_W-1:0] data_q;
	logic [IDX_W:0]   pos_x;
	logic [IDX_W:0]   cnt_x;
	logic             at_pos;
	logic             above_pos;
	logic             below_pos;
	logic             at_cnt;
	logic             upto_cnt;
	logic             from_cnt;
	logic             before_last;
	sel_t             sel;

	// compare own index against the broadcast bounds
	assign pos_x       = {1'b0, pos};
	assign cnt_x       = {1'b0, cnt};
	assign at_pos      = (IDX_C == pos_x);
	assign above_pos   = (IDX_C > pos_x);
	assign below_pos   = (IDX_C < pos_x);
	assign at_cnt      = (IDX_C == cnt_x);
	assign upto_cnt    = (IDX_C <= cnt_x);
	assign from_cnt    = (IDX_C >= cnt_x);
	assign before_last = (NEXT_C < cnt_x);

	// pick the source of the next entry
	always_comb begin
		sel = SEL_HOLD;
		case (ctl.kind)
			CK_WRITE: begin
				if (at_pos) sel = SEL_LOAD;
			end
			CK_INSERT: begin
				if (at_pos) sel = SEL_LOAD;
				else if (above_pos && upto_cnt) sel = SEL_LEFT;
			end
			CK_ERASE: begin
				if (!below_pos && before_last) sel = SEL_RIGHT;
			end
			CK_PUSH: begin
				if (at_cnt) sel = SEL_LOAD;
			end
			CK_FILL: begin
				if (from_cnt && below_pos) sel = SEL_LOAD;
			end
			default: begin
				sel = SEL_HOLD;
			end
		endcase
		if (!ctl.take) sel = SEL_HOLD;
	end

	// update the entry
	always_ff @(posedge clk) begin
		case (sel)
			SEL_LOAD:  data_q <= value;
			SEL_LEFT:  data_q <= left;
			SEL_RIGHT: data_q <= right;
			default:   data_q <= data_q;
		endcase
	end

	// capture the entry for an accepted read at this index, zero for any other accepted command
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			rd_s1 <= (ctl.kind == CK_READ && at_pos) ? data_q : '0;
		end
	end

	assign data = data_q;

endmodule

### hdl/shifting_array_list_core.sv
// Pipeline: two register stages, stage one and the output register; a
// command moves on to the output register when that register is free.
// Throughput: one command per cycle unless m_tready stalls; every cell shifts
// or loads in parallel; reads are a registered cell capture then an OR tree.
// Reset: the element count and the pipeline valids clear at once; the
// entries themselves keep whatever they hold and are not cleared.
// ----------------------------------------------------------------------------
// shifting_array_list_core: bounded ordered list of unsigned 32-bit entries
// Row of cells with read, write, insert, erase, push, pop, clear and resize.
// ----------------------------------------------------------------------------
module shifting_array_list_core #(
	parameter int unsigned CAPACITY = sal_pkg::DEF_CAPACITY
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [6:0] position, [38:7] value, [39] zero
	input  logic [sal_pkg::IN_DATA_W-1:0]  s_tdata,
	// [2:0] operation
	input  logic [sal_pkg::OP_W-1:0]       s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] read_value, [38:32] count, [39] is_empty
	output logic [sal_pkg::OUT_DATA_W-1:0] m_tdata,
	// [0] error
	output logic                           m_tuser
);
	import sal_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAPACITY);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [POS_W-1:0] pos;
	logic [VAL_W-1:0] value;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	op_t              op;
	logic             acc;
	logic             err;
	cell_kind_t       kind;
	cell_ctl_t        ctl;

	logic             valid_s1;
	logic [CNT_W-1:0] count_s1;
	logic             err_s1;
	logic             read_s1;
	logic             move_s1;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_rd_q;
	logic [CNT_W-1:0] out_count_q;
	logic             out_err_q;
	logic             out_empty_q;

	logic [VAL_W-1:0] cell_data [CAPACITY];
	logic [VAL_W-1:0] cell_rd   [CAPACITY];
	logic [VAL_W-1:0] rd_or;

	// unpack the command
	assign pos   = s_tdata[POS_W-1:0];
	assign value = s_tdata[POS_W +: VAL_W];
	assign op    = op_t'(s_tuser);
	assign pos_x = CMP_W'(pos);
	assign cnt_x = CMP_W'(count_q);

	// handshake: stage one drains into the output register
	assign move_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || move_s1;
	assign acc      = s_tvalid && s_tready;

	// check bounds, pick the cell action and the next count
	always_comb begin
		err       = 1'b0;
		kind      = CK_NONE;
		count_nxt = count_q;
		case (op)
			OP_READ: begin
				err  = (pos_x >= cnt_x);
				kind = CK_READ;
			end
			OP_WRITE: begin
				err  = (pos_x >= cnt_x);
				kind = CK_WRITE;
			end
			OP_INSERT: begin
				err       = (pos_x > cnt_x) || (cnt_x == CAP_C);
				kind      = CK_INSERT;
				count_nxt = count_q + 1'b1;
			end
			OP_ERASE: begin
				err       = (pos_x >= cnt_x);
				kind      = CK_ERASE;
				count_nxt = count_q - 1'b1;
			end
			OP_PUSH: begin
				err       = (cnt_x == CAP_C);
				kind      = CK_PUSH;
				count_nxt = count_q + 1'b1;
			end
			OP_POP: begin
				err       = (count_q == '0);
				count_nxt = count_q - 1'b1;
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			OP_RESIZE: begin
				err       = (pos_x > CAP_C);
				kind      = CK_FILL;
				count_nxt = CNT_W'(pos_x);
			end
			default: begin
				err = 1'b1;
			end
		endcase
		if (err) begin
			kind      = CK_NONE;
			count_nxt = count_q;
		end
	end

	assign ctl.take = acc;
	assign ctl.kind = kind;

	// advance the element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= count_nxt;
		end
	end

	// row of cells, each handing its entry to its left and right neighbors where they exist
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [VAL_W-1:0] left;
		logic [VAL_W-1:0] right;
		if (k == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_data[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_data[k+1];
		end
		sal_cell #(
			.IDX_W (CMP_W),
			.INDEX (k)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (pos_x),
			.cnt   (cnt_x),
			.value (value),
			.left  (left),
			.right (right),
			.data  (cell_data[k]),
			.rd_s1 (cell_rd[k])
		);
	end

	// stage one status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			count_s1 <= count_nxt;
			err_s1   <= err;
			read_s1  <= (kind == CK_READ);
		end
	end

	// merge the cell captures; only the addressed cell is nonzero
	always_comb begin
		rd_or = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_or = rd_or | cell_rd[k];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_rd_q    <= read_s1 ? rd_or : '0;
			out_count_q <= count_s1;
			out_err_q   <= err_s1;
			out_empty_q <= (count_s1 == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_empty_q, COUNT_W'(out_count_q), out_rd_q};
	assign m_tuser  = out_err_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_N)
		else $error("element count above capacity");

	a_err_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && err) |=> (count_q == $past(count_q)))
		else $error("rejected command changed the count");

	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !read_s1) |-> (rd_or == '0))
		else $error("cell capture nonzero outside a read");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_empty_q == (out_count_q == '0)))
		else $error("empty flag disagrees with count");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !move_s1) |-> !s_tready)
		else $error("transfer accepted over a held stage");
`endif

endmodule
